FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KG_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define KG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: design/kgsc_pkg.sv
// ----------------------------------------------------------------------------
// kgsc_pkg
// types and constants shared by the keyed grid shift cipher modules
// ----------------------------------------------------------------------------
package kgsc_pkg;

  localparam int LETTER_COUNT    = 26;
  localparam int MAX_KEY_LETTERS = 26;
  localparam int LETTER_W        = 5;
  localparam int CHAR_W          = 8;
  localparam int KEY_LEN_W       = 5;
  localparam int KEY_WIDE_W      = 60;
  localparam int KEY_HIGH_W      = 10;
  localparam int CFG_DATA_W      = 60;
  localparam int CFG_INDEX_W     = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z = 8'h7a;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // shift rule on alphabet positions
  localparam logic [LETTER_W-1:0] LAST_POS  = 5'd25;
  localparam logic [LETTER_W-1:0] WRAP_SPAN = 5'd20;
  localparam logic [LETTER_W-1:0] SHIFT     = 5'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_LENGTH,
    REG_KEY_LOW,
    REG_KEY_MID,
    REG_KEY_HIGH
  } cfg_reg_t;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t [LETTER_COUNT-1:0] letter_tab_t;

  typedef struct packed {
    logic              cmd;
    logic              is_letter;
    logic [CHAR_W-1:0] ch;
    letter_t           pos;
  } kgsc_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

FILE: design/keyed_grid_shift_cipher_unit.sv
// ----------------------------------------------------------------------------
// keyed_grid_shift_cipher_unit
// keyed-alphabet substitution of one byte per beat, encrypt or decrypt
// ----------------------------------------------------------------------------
// request channel: req_valid / req_stall with cmd and char_in per beat.
// response channel: rsp_valid / rsp_stall with char_out, one per request,
// in request order. non-lowercase bytes come back unchanged.
// configuration: cfg_we writes cfg_data into register cfg_index (key length,
// low, mid, high key letter words). write only while no beat is in flight.
// each write restarts the alphabet build: req_stall stays high while the
// key phase walks the key letters (length capped at 26) and the fill phase
// walks a..z. reset clears the key registers and runs the same build.
// a taken beat goes into the queue, then is popped into the response
// register for char_out. one beat per cycle while req_stall is low;
// lookup is a table read per stage. when the receiver stalls, the response
// register holds and a two-entry queue absorbs beats before req_stall rises.
// ----------------------------------------------------------------------------
module keyed_grid_shift_cipher_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             cmd,
  input  logic [kgsc_pkg::CHAR_W-1:0]      char_in,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [kgsc_pkg::CHAR_W-1:0]      char_out,
  input  logic                             cfg_we,
  input  logic [kgsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kgsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kgsc_pkg::*;

  logic          busy;
  letter_tab_t   alpha_tab;
  letter_tab_t   pos_tab;
  queue_status_t q_stat;
  kgsc_item_t    push_item;
  kgsc_item_t    head;
  logic          push;
  logic          pop;

  kgsc_keytab u_keytab (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .alpha_tab (alpha_tab),
    .pos_tab   (pos_tab)
  );

  kgsc_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .char_in   (char_in),
    .busy      (busy),
    .q_stat    (q_stat),
    .pos_tab   (pos_tab),
    .push      (push),
    .item      (push_item)
  );

  kgsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  kgsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .alpha_tab (alpha_tab),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .char_out  (char_out)
  );

endmodule

FILE: design/kgsc_keytab.sv
// ----------------------------------------------------------------------------
// kgsc_keytab
// key registers and the sequencer that builds the keyed alphabet tables
// ----------------------------------------------------------------------------
module kgsc_keytab (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kgsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kgsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             busy,
  output kgsc_pkg::letter_tab_t            alpha_tab,
  output kgsc_pkg::letter_tab_t            pos_tab
);
  import kgsc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_KEY, S_FILL} state_t;

  logic [KEY_LEN_W-1:0]    key_length;
  logic [KEY_WIDE_W-1:0]   key_low;
  logic [KEY_WIDE_W-1:0]   key_mid;
  logic [KEY_HIGH_W-1:0]   key_high;

  state_t                  state;
  letter_t                 idx;
  logic [LETTER_W-1:0]     count;
  logic [LETTER_COUNT-1:0] used;

  letter_tab_t             key_tab;
  logic [KEY_LEN_W-1:0]    limit;
  letter_t                 cand;
  logic                    cand_ok;
  logic                    in_key;
  logic                    take;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      key_low    <= '0;
      key_mid    <= '0;
      key_high   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        REG_KEY_LOW:    key_low    <= cfg_data[KEY_WIDE_W-1:0];
        REG_KEY_MID:    key_mid    <= cfg_data[KEY_WIDE_W-1:0];
        REG_KEY_HIGH:   key_high   <= cfg_data[KEY_HIGH_W-1:0];
      endcase
    end
  end

  assign key_tab = {key_high, key_mid, key_low};
  assign limit   = (key_length > KEY_LEN_W'(MAX_KEY_LETTERS)) ?
                   KEY_LEN_W'(MAX_KEY_LETTERS) : key_length;

  // key phase walks the key letters, fill phase walks a..z
  always_comb begin
    cand    = (state == S_KEY) ? key_tab[idx] : idx;
    cand_ok = (cand < LETTER_W'(LETTER_COUNT)) && !used[cand];
    in_key  = (state == S_KEY) && (idx < limit);
    take    = (in_key || (state == S_FILL)) && cand_ok;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_KEY;
      idx   <= '0;
      count <= '0;
      used  <= '0;
    end else begin
      unique case (state)
        S_IDLE: ;
        S_KEY: begin
          if (idx < limit) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_FILL;
            idx   <= '0;
          end
        end
        S_FILL: begin
          if (idx == LETTER_W'(LETTER_COUNT - 1)) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (take) begin
        used[cand] <= 1'b1;
        count      <= count + 1'b1;
      end
    end
    if (take) begin
      alpha_tab[count] <= cand;
      pos_tab[cand]    <= count;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: design/kgsc_front.sv
// ----------------------------------------------------------------------------
// kgsc_front
// accepts request beats, classifies the byte and looks up its key position
// ----------------------------------------------------------------------------
module kgsc_front (
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        cmd,
  input  logic [kgsc_pkg::CHAR_W-1:0] char_in,
  input  logic                        busy,
  input  kgsc_pkg::queue_status_t     q_stat,
  input  kgsc_pkg::letter_tab_t       pos_tab,
  output logic                        push,
  output kgsc_pkg::kgsc_item_t        item
);
  import kgsc_pkg::*;

  logic    is_lower;
  letter_t letter;

  always_comb begin
    is_lower       = (char_in >= LOWER_A) && (char_in <= LOWER_Z);
    letter         = is_lower ? LETTER_W'(char_in - LOWER_A) : '0;
    item.cmd       = cmd;
    item.is_letter = is_lower;
    item.ch        = char_in;
    item.pos       = pos_tab[letter];
  end

  assign req_stall = busy || q_stat.full;
  assign push      = req_valid && !req_stall;

endmodule

FILE: design/kgsc_queue.sv
// ----------------------------------------------------------------------------
// kgsc_queue
// short fifo between the classifying front and the substituting back
// ----------------------------------------------------------------------------
module kgsc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  kgsc_pkg::kgsc_item_t    push_item,
  input  logic                    pop,
  output kgsc_pkg::kgsc_item_t    head,
  output kgsc_pkg::queue_status_t q_stat
);
  import kgsc_pkg::*;

  kgsc_item_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head         = entries[rd_ptr];
  assign q_stat.empty = (cnt == '0);
  assign q_stat.full  = (cnt == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

FILE: design/kgsc_back.sv
// ----------------------------------------------------------------------------
// kgsc_back
// applies the position shift, maps back through the alphabet, holds result
// ----------------------------------------------------------------------------
module kgsc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  kgsc_pkg::queue_status_t     q_stat,
  input  kgsc_pkg::kgsc_item_t        head,
  input  kgsc_pkg::letter_tab_t       alpha_tab,
  output logic                        pop,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [kgsc_pkg::CHAR_W-1:0] char_out
);
  import kgsc_pkg::*;

  letter_t           q;
  logic [CHAR_W-1:0] result;

  always_comb begin
    if (head.cmd == CMD_ENCRYPT) begin
      priority if (head.pos == LAST_POS) begin
        q = '0;
      end else if (head.pos > WRAP_SPAN) begin
        q = head.pos - WRAP_SPAN;
      end else begin
        q = head.pos + SHIFT;
      end
    end else begin
      priority if (head.pos == '0) begin
        q = LAST_POS;
      end else if (head.pos < SHIFT) begin
        q = head.pos + WRAP_SPAN;
      end else begin
        q = head.pos - SHIFT;
      end
    end
    result = head.is_letter ? CHAR_W'(LOWER_A + CHAR_W'(alpha_tab[q])) : head.ch;
  end

  assign pop = !q_stat.empty && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (pop) begin
      char_out <= result;
    end
  end

endmodule

FILE: design/kgsc_checker.sv
// ----------------------------------------------------------------------------
// kgsc_checker
// port-level checks on the cipher unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kgsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [kgsc_pkg::CHAR_W-1:0] char_out,
  input logic                        cfg_we
);
  import kgsc_pkg::*;

  // a key write always triggers a table rebuild that blocks requests
  `KG_ASSERT_NEXT(a_cfg_rebuild, cfg_we, req_stall)
  // the build after reset also blocks requests
  `KG_ASSERT_HOLDS(a_reset_rebuild, $past(rst) && !rst, req_stall)
  `KG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
  `KG_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(char_out))

endmodule

bind keyed_grid_shift_cipher_unit kgsc_checker u_checker (.*);
